// ----- rtl/core/qvr_pkg.sv -----
package qvr_pkg;

   localparam int VEC_WIDTH      = 32;
   localparam int QUAT_FRAC_BITS = 30;
   localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;

   // quaternion pair products and the sums built from them (2F fraction bits)
   localparam int PROD_W     = 2 * QUAT_WIDTH;
   localparam int SUM_W      = PROD_W + 2;
   // rounded matrix entry, F fraction bits
   localparam int ENT_W      = SUM_W - QUAT_FRAC_BITS;
   // entry times vector component, and the three-term row sum
   localparam int MAC_PROD_W = ENT_W + VEC_WIDTH;
   localparam int ACC_W      = MAC_PROD_W + 2;
   localparam int RND_W      = ACC_W - QUAT_FRAC_BITS;

   localparam logic [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (QUAT_FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (QUAT_FRAC_BITS - 1);

   localparam logic [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
   localparam logic [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

   localparam logic CMD_B_TO_A = 1'b0;
   localparam logic CMD_A_TO_B = 1'b1;

   typedef struct packed {
      logic                          cmd;
      logic signed [QUAT_WIDTH-1:0]  quat_x;
      logic signed [QUAT_WIDTH-1:0]  quat_y;
      logic signed [QUAT_WIDTH-1:0]  quat_z;
      logic signed [QUAT_WIDTH-1:0]  quat_s;
      logic signed [VEC_WIDTH-1:0]   vec_x;
      logic signed [VEC_WIDTH-1:0]   vec_y;
      logic signed [VEC_WIDTH-1:0]   vec_z;
   } qvr_req_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0]   rot_x;
      logic signed [VEC_WIDTH-1:0]   rot_y;
      logic signed [VEC_WIDTH-1:0]   rot_z;
      logic                          overflow;
   } qvr_rsp_type;

   // rotation matrix, with the transpose already applied for CMD_A_TO_B, plus the vector
   typedef struct packed {
      logic [2:0][2:0][ENT_W-1:0]    m;
      logic [2:0][VEC_WIDTH-1:0]     v;
   } qvr_mat_type;

   function automatic logic [SUM_W-1:0] ext_prod(input logic [PROD_W-1:0] p);
      return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   function automatic logic [ACC_W-1:0] ext_mac(input logic [MAC_PROD_W-1:0] p);
      return {{(ACC_W-MAC_PROD_W){p[MAC_PROD_W-1]}}, p};
   endfunction

   // round half up, then arithmetic shift right by F
   function automatic logic [ENT_W-1:0] round_ent(input logic [SUM_W-1:0] e);
      logic [SUM_W-1:0] t;
      t = e + SUM_HALF;
      return t[SUM_W-1:QUAT_FRAC_BITS];
   endfunction

   function automatic logic [RND_W-1:0] round_acc(input logic [ACC_W-1:0] a);
      logic [ACC_W-1:0] t;
      t = a + ACC_HALF;
      return t[ACC_W-1:QUAT_FRAC_BITS];
   endfunction

endpackage

// ----- rtl/core/qvr_dcm.sv -----
module qvr_dcm import qvr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  qvr_req_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output qvr_mat_type out_data
);

   typedef struct packed {
      logic signed [PROD_W-1:0] xx, yy, zz, ss, xy, xz, xs, yz, ys, zs;
   } qvr_prod_type;

   // stage 1: pair products
   logic                       vld1_ff, rdy1;
   qvr_prod_type               prod_ff, prod_in;
   logic [2:0][VEC_WIDTH-1:0]  vec1_ff;
   logic                       cmd1_ff;

   // stage 2: matrix entries at full precision
   logic                          vld2_ff, rdy2;
   logic [2:0][2:0][SUM_W-1:0]    sum_ff, sum_in;
   logic [2:0][VEC_WIDTH-1:0]     vec2_ff;
   logic                          cmd2_ff;

   // stage 3: rounded, oriented matrix
   logic        vld3_ff, rdy3;
   qvr_mat_type mat_ff, mat_in;

   assign rdy3     = !vld3_ff || out_ready;
   assign rdy2     = !vld2_ff || rdy3;
   assign rdy1     = !vld1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      prod_in.xx = in_data.quat_x * in_data.quat_x;
      prod_in.yy = in_data.quat_y * in_data.quat_y;
      prod_in.zz = in_data.quat_z * in_data.quat_z;
      prod_in.ss = in_data.quat_s * in_data.quat_s;
      prod_in.xy = in_data.quat_x * in_data.quat_y;
      prod_in.xz = in_data.quat_x * in_data.quat_z;
      prod_in.xs = in_data.quat_x * in_data.quat_s;
      prod_in.yz = in_data.quat_y * in_data.quat_z;
      prod_in.ys = in_data.quat_y * in_data.quat_s;
      prod_in.zs = in_data.quat_z * in_data.quat_s;
   end

   always_comb begin
      logic [SUM_W-1:0] exx, eyy, ezz, ess, exy, exz, exs, eyz, eys, ezs;
      logic [SUM_W-1:0] t01, t02, t10, t12, t20, t21;
      exx = ext_prod(prod_ff.xx);
      eyy = ext_prod(prod_ff.yy);
      ezz = ext_prod(prod_ff.zz);
      ess = ext_prod(prod_ff.ss);
      exy = ext_prod(prod_ff.xy);
      exz = ext_prod(prod_ff.xz);
      exs = ext_prod(prod_ff.xs);
      eyz = ext_prod(prod_ff.yz);
      eys = ext_prod(prod_ff.ys);
      ezs = ext_prod(prod_ff.zs);
      t01 = exy + ezs;
      t02 = exz - eys;
      t10 = exy - ezs;
      t12 = eyz + exs;
      t20 = exz + eys;
      t21 = eyz - exs;
      sum_in[0][0] = exx - eyy - ezz + ess;
      sum_in[1][1] = eyy - exx - ezz + ess;
      sum_in[2][2] = ezz - exx - eyy + ess;
      // factor of two on the off-diagonal terms
      sum_in[0][1] = {t01[SUM_W-2:0], 1'b0};
      sum_in[0][2] = {t02[SUM_W-2:0], 1'b0};
      sum_in[1][0] = {t10[SUM_W-2:0], 1'b0};
      sum_in[1][2] = {t12[SUM_W-2:0], 1'b0};
      sum_in[2][0] = {t20[SUM_W-2:0], 1'b0};
      sum_in[2][1] = {t21[SUM_W-2:0], 1'b0};
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (cmd2_ff == CMD_A_TO_B) begin
               mat_in.m[r][c] = round_ent(sum_ff[c][r]);
            end else begin
               mat_in.m[r][c] = round_ent(sum_ff[r][c]);
            end
         end
      end
      mat_in.v = vec2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= in_valid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff <= prod_in;
         vec1_ff <= {in_data.vec_z, in_data.vec_y, in_data.vec_x};
         cmd1_ff <= in_data.cmd;
      end
      if (rdy2) begin
         sum_ff  <= sum_in;
         vec2_ff <= vec1_ff;
         cmd2_ff <= cmd1_ff;
      end
      if (rdy3) begin
         mat_ff <= mat_in;
      end
   end

   assign out_valid = vld3_ff;
   assign out_data  = mat_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      vld3_ff && !out_ready |=> vld3_ff && $stable(mat_ff))
      else $error("dcm: stalled beat lost or changed");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      vld2_ff && !rdy2 |=> vld2_ff && $stable(sum_ff))
      else $error("dcm: stage 2 overwritten while stalled");

endmodule

// ----- rtl/core/qvr_mac.sv -----
module qvr_mac import qvr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  qvr_mat_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output qvr_rsp_type out_data
);

   // stage 4: entry times vector component
   logic                             vld4_ff, rdy4;
   logic [2:0][2:0][MAC_PROD_W-1:0]  prod_ff, prod_in;

   // stage 5: row sums
   logic                        vld5_ff, rdy5;
   logic [2:0][ACC_W-1:0]       acc_ff, acc_in;

   // stage 6: rounded, saturated result
   logic        vld6_ff, rdy6;
   qvr_rsp_type rsp_ff, rsp_in;

   assign rdy6     = !vld6_ff || out_ready;
   assign rdy5     = !vld5_ff || rdy6;
   assign rdy4     = !vld4_ff || rdy5;
   assign in_ready = rdy4;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(in_data.m[r][c]) * $signed(in_data.v[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = ext_mac(prod_ff[r][0]) + ext_mac(prod_ff[r][1])
                   + ext_mac(prod_ff[r][2]);
      end
   end

   always_comb begin
      logic [2:0][RND_W-1:0]     rnd;
      logic [2:0][VEC_WIDTH-1:0] rot;
      logic [2:0]                sat;
      logic [RND_W-VEC_WIDTH:0]  top;
      for (int r = 0; r < 3; r++) begin
         rnd[r] = round_acc(acc_ff[r]);
         top    = rnd[r][RND_W-1:VEC_WIDTH-1];
         // in range when the bits above the sign all copy it
         sat[r] = !((&top) || !(|top));
         if (sat[r]) begin
            rot[r] = rnd[r][RND_W-1] ? VEC_MIN : VEC_MAX;
         end else begin
            rot[r] = rnd[r][VEC_WIDTH-1:0];
         end
      end
      rsp_in.rot_x    = rot[0];
      rsp_in.rot_y    = rot[1];
      rsp_in.rot_z    = rot[2];
      rsp_in.overflow = |sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else begin
         if (rdy4) vld4_ff <= in_valid;
         if (rdy5) vld5_ff <= vld4_ff;
         if (rdy6) vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) prod_ff <= prod_in;
      if (rdy5) acc_ff  <= acc_in;
      if (rdy6) rsp_ff  <= rsp_in;
   end

   assign out_valid = vld6_ff;
   assign out_data  = rsp_ff;

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      vld6_ff && rsp_ff.overflow |->
         rsp_ff.rot_x == VEC_MAX || rsp_ff.rot_x == VEC_MIN ||
         rsp_ff.rot_y == VEC_MAX || rsp_ff.rot_y == VEC_MIN ||
         rsp_ff.rot_z == VEC_MAX || rsp_ff.rot_z == VEC_MIN)
      else $error("mac: overflow flagged without a clamped component");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("mac: pipeline stalls while the output drains");

endmodule

// ----- rtl/core/quaternion_vector_rotate_unit.sv -----
// Rotates a 3-vector by an attitude quaternion (x, y, z vector part, s scalar,
// signed Q2.30), as R*v with cmd 0 (B into A) or R^T*v with cmd 1 (A into B).
// The quaternion is not normalized, so a non-unit q scales the result by |q|^2.
// Matrix entries and results round half up; a component that leaves the
// 32-bit range clamps to the nearest bound and sets overflow. The datapath is
// a six-stage pipeline: ten 32x32 quaternion products, matrix sums, rounding
// and orientation, nine 36x32 entry-by-component products, row sums, then
// round and clamp. It takes one beat per clock unless the pipeline is full
// and rsp_ready is low. Each stage stalls on its own, so bubbles collapse
// and requests keep flowing until every stage holds a beat.
module quaternion_vector_rotate_unit import qvr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  qvr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output qvr_rsp_type rsp_data
);

   logic        mat_valid;
   logic        mat_ready;
   qvr_mat_type mat_data;

   qvr_dcm u_dcm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_data  (mat_data)
   );

   qvr_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_data   (mat_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
